// File: hdl/merge_insertion_sorter_core_macros.svh
// Assertion macros for the merge insertion sorter.
// Used by the top level only; needs clk_i and rst_ni in scope.
`ifndef MERGE_INSERTION_SORTER_CORE_MACROS_SVH
`define MERGE_INSERTION_SORTER_CORE_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define MIS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same check, with the reset qualifier spelled out by the caller.
`define MIS_ASSERT_RST(lbl, rst, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (rst) prop) else $error(msg);

`endif

// File: hdl/mis_pkg.sv
// Shared constants for the merge insertion sorter.
// No dependencies.
`timescale 1ns / 1ps
package mis_pkg;
  localparam int unsigned MaxItems = 64;
  localparam int unsigned ValW     = 31;
endpackage

// File: hdl/mis_ram.sv
// Simple dual-port synchronous RAM with registered read data.
// Depends on mis_pkg for default depth and width.
`timescale 1ns / 1ps
module mis_ram
  import mis_pkg::*;
#(
  parameter int unsigned Depth = MaxItems,
  parameter int unsigned Width = ValW
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port: data is registered and appears the cycle after re_i; it holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end
endmodule

// File: hdl/merge_insertion_sorter_core.sv
// Batch sorter: loads values one per cycle, sorts them in a chain memory, emits ascending.
// Loading: one request per cycle. Sorting: each value is inserted by shifting the
// chain memory one entry per cycle (read, compare, write back), then written into
// the place left free.
// Emitting: each result is read from the chain memory, then held until it is taken.
// Reset clears all control state; memories hold no reset value and need no clearing.
`timescale 1ns / 1ps
`include "merge_insertion_sorter_core_macros.svh"
module merge_insertion_sorter_core
  import mis_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = MaxItems
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [ValW-1:0] value_i,
  input  logic            last_item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [ValW-1:0] sorted_value_o,
  output logic            last_result_o,
  output logic            dropped_flag_o
);
  localparam int unsigned AW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam logic [CW-1:0] CntMax = CW'(MAX_ITEMS);
  localparam logic [CW-1:0] One = CW'(1);

  localparam logic [2:0] SLoad  = 3'd0;
  localparam logic [2:0] SFetch = 3'd1;
  localparam logic [2:0] SGet   = 3'd2;
  localparam logic [2:0] SCmp   = 3'd3;
  localparam logic [2:0] SPlace = 3'd4;
  localparam logic [2:0] SERd   = 3'd5;
  localparam logic [2:0] SEOut  = 3'd6;

  logic [2:0]      state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic [CW-1:0]   pos_q, pos_d;
  logic            ovf_q, ovf_d;
  logic [ValW-1:0] item_q, item_d;

  logic            ld_we, ld_re, ch_we, ch_re;
  logic [AW-1:0]   ld_waddr, ld_raddr, ch_waddr, ch_raddr;
  logic [ValW-1:0] ld_rdata, ch_wdata, ch_rdata;

  logic in_req, out_req;
  assign in_req  = in_valid_i && in_ready_o;
  assign out_req = out_valid_o && out_ready_i;

  mis_ram #(.Depth(MAX_ITEMS), .Width(ValW)) u_load_ram (
    .clk_i, .we_i(ld_we), .waddr_i(ld_waddr), .wdata_i(value_i),
    .re_i(ld_re), .raddr_i(ld_raddr), .rdata_o(ld_rdata)
  );

  mis_ram #(.Depth(MAX_ITEMS), .Width(ValW)) u_chain_ram (
    .clk_i, .we_i(ch_we), .waddr_i(ch_waddr), .wdata_i(ch_wdata),
    .re_i(ch_re), .raddr_i(ch_raddr), .rdata_o(ch_rdata)
  );

  // Control sequencer: load, insert each value into the chain, then emit.
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    pos_d    = pos_q;
    ovf_d    = ovf_q;
    item_d   = item_q;
    ld_we    = 1'b0;
    ld_re    = 1'b0;
    ch_we    = 1'b0;
    ch_re    = 1'b0;
    ld_waddr = cnt_q[AW-1:0];
    ld_raddr = idx_q[AW-1:0];
    ch_waddr = pos_q[AW-1:0];
    ch_wdata = item_q;
    ch_raddr = idx_q[AW-1:0];
    case (state_q)
      SLoad: begin
        if (in_req) begin
          if (cnt_q < CntMax) begin
            ld_we = 1'b1;
            cnt_d = cnt_q + One;
          end else begin
            ovf_d = 1'b1;
          end
          if (last_item_i) begin
            idx_d   = '0;
            state_d = SFetch;
          end
        end
      end
      SFetch: begin
        ld_re   = 1'b1;
        state_d = SGet;
      end
      SGet: begin
        // The chain already holds idx_q values; start comparing at its end.
        item_d = ld_rdata;
        pos_d  = idx_q;
        if (idx_q == '0) begin
          state_d = SPlace;
        end else begin
          ch_re    = 1'b1;
          ch_raddr = AW'(idx_q - One);
          state_d  = SCmp;
        end
      end
      SCmp: begin
        if (ch_rdata > item_q) begin
          // Shift the larger entry up one place and look further down.
          ch_we    = 1'b1;
          ch_wdata = ch_rdata;
          pos_d    = pos_q - One;
          if (pos_q == One) begin
            state_d = SPlace;
          end else begin
            ch_re    = 1'b1;
            ch_raddr = AW'(pos_q - CW'(2));
          end
        end else begin
          state_d = SPlace;
        end
      end
      SPlace: begin
        ch_we = 1'b1;
        idx_d = idx_q + One;
        if (idx_q + One == cnt_q) begin
          idx_d   = '0;
          state_d = SERd;
        end else begin
          state_d = SFetch;
        end
      end
      SERd: begin
        ch_re   = 1'b1;
        state_d = SEOut;
      end
      SEOut: begin
        if (out_req) begin
          if (idx_q + One == cnt_q) begin
            cnt_d   = '0;
            ovf_d   = 1'b0;
            state_d = SLoad;
          end else begin
            idx_d   = idx_q + One;
            state_d = SERd;
          end
        end
      end
      default: state_d = SLoad;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SLoad;
      cnt_q   <= '0;
      idx_q   <= '0;
      pos_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      pos_q   <= pos_d;
      ovf_q   <= ovf_d;
    end
  end

  // Value under insertion.
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  // Port outputs.
  assign in_ready_o     = (state_q == SLoad);
  assign out_valid_o    = (state_q == SEOut);
  assign sorted_value_o = ch_rdata;
  assign last_result_o  = (idx_q + One == cnt_q);
  assign dropped_flag_o = ovf_q;

  // Checks.
  `MIS_ASSERT(a_no_overlap, out_valid_o |-> !in_ready_o, "result while loading")
  `MIS_ASSERT(a_cnt_range, cnt_q <= CntMax, "item count beyond capacity")
  `MIS_ASSERT_RST(a_last_stops, !rst_ni, in_req && last_item_i |=> !in_ready_o,
                  "request accepted after last item")
endmodule

// File: test/tb_top.sv
// Testbench for the merge insertion sorter core: random batches, stalls and overflow.
// Depends on mis_pkg and merge_insertion_sorter_core; predicts sorted output in place.
`timescale 1ns / 1ps
module tb_top;
  import mis_pkg::*;

  localparam int unsigned Cap      = MaxItems;
  localparam int unsigned WdogMax  = 200000;
  localparam int unsigned TailWait = 50;

  typedef struct packed {
    logic [ValW-1:0] value;
    logic            last;
  } req_t;

  typedef struct packed {
    logic [ValW-1:0] value;
    logic            last;
    logic            dropped;
  } res_t;

  logic            clk_i;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_ready_o;
  logic [ValW-1:0] value_i;
  logic            last_item_i;
  logic            out_valid_o;
  logic            out_ready_i;
  logic [ValW-1:0] sorted_value_o;
  logic            last_result_o;
  logic            dropped_flag_o;

  req_t pending_reqs[$];
  res_t sorted_expect[$];
  logic [ValW-1:0] batch_vals[$];
  logic batch_over;
  int unsigned fail_cnt;
  int unsigned idle_cycles;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned hold_left;
  bit hold_req;
  bit drain_req;
  bit in_acc;

  merge_insertion_sorter_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .value_i        (value_i),
    .last_item_i    (last_item_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sorted_value_o (sorted_value_o),
    .last_result_o  (last_result_o),
    .dropped_flag_o (dropped_flag_o)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Predict one accepted request: store it, and on the last one emit the sorted batch.
  task automatic predict_sorted(input req_t r);
    logic [ValW-1:0] s[$];
    res_t e;
    begin
      if (batch_vals.size() < Cap) batch_vals.insert(batch_vals.size(), r.value);
      else batch_over = 1'b1;
      if (r.last) begin
        s = batch_vals;
        s.sort();
        foreach (s[i]) begin
          e.value   = s[i];
          e.last    = (i == s.size() - 1);
          e.dropped = batch_over;
          sorted_expect.insert(sorted_expect.size(), e);
        end
        batch_vals.delete();
        batch_over = 1'b0;
      end
    end
  endtask

  // Random value with a bias toward extremes and repeats.
  function automatic logic [ValW-1:0] pick_value(input int unsigned sel);
    case (sel)
      0: return '0;
      1: return '1;
      2: return ValW'($urandom_range(0, 7));
      default: return ValW'($urandom);
    endcase
  endfunction

  // Queue one batch of the given length.
  task automatic queue_batch(input int unsigned len, input int unsigned mode);
    req_t r;
    begin
      for (int unsigned i = 0; i < len; i++) begin
        r.value = pick_value(mode == 0 ? $urandom_range(0, 6) : mode);
        r.last  = (i == len - 1);
        pending_reqs.insert(pending_reqs.size(), r);
      end
    end
  endtask

  // Input acceptance seen at the last rising edge, used by the driver.
  always @(posedge clk_i) begin
    in_acc <= rst_ni && in_valid_i && in_ready_o;
  end

  // Driver: bursts with gaps; valid holds until accepted.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      value_i     <= '0;
      last_item_i <= 1'b0;
      burst_left  <= 0;
      gap_left    <= 0;
    end else begin
      if (in_acc) begin
        void'(pending_reqs.pop_front());
      end
      if (in_valid_i && !in_acc) begin
        // Keep offering the same request until it is accepted.
      end else if (drain_req && sorted_expect.size() != 0) begin
        in_valid_i <= 1'b0;
      end else if (gap_left != 0) begin
        gap_left   <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        in_valid_i  <= 1'b1;
        value_i     <= pending_reqs[0].value;
        last_item_i <= pending_reqs[0].last;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 20);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver stall pattern, with one long hold-off on request.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left   <= 0;
    end else if (hold_req && hold_left == 0) begin
      hold_left   <= 4000;
      out_ready_i <= 1'b0;
    end else if (hold_left > 1) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      hold_left   <= 0;
      out_ready_i <= ($urandom_range(0, 15) < 11);
    end
  end

  // Monitor: predict on input acceptance, compare on output acceptance.
  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predict_sorted('{value: value_i, last: last_item_i});
      end
      if (out_valid_o && out_ready_i) begin
        if (sorted_expect.size() == 0) begin
          $error("unexpected result value=%0h", sorted_value_o);
          fail_cnt++;
        end else begin
          e = sorted_expect.pop_front();
          if (sorted_value_o !== e.value) begin
            $error("sorted_value exp=%0h act=%0h", e.value, sorted_value_o);
            fail_cnt++;
          end
          if (last_result_o !== e.last) begin
            $error("last_result exp=%0b act=%0b", e.last, last_result_o);
            fail_cnt++;
          end
          if (dropped_flag_o !== e.dropped) begin
            $error("dropped_flag exp=%0b act=%0b", e.dropped, dropped_flag_o);
            fail_cnt++;
          end
        end
      end
    end
  end

  // Watchdog on cycles without any accepted request.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WdogMax) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus and end of run.
  initial begin
    int unsigned total;
    fail_cnt   = 0;
    batch_over = 1'b0;
    hold_req   = 1'b0;
    drain_req  = 1'b0;
    rst_ni     = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: single item, pair, all ones, small values with duplicates.
    queue_batch(1, 1);
    queue_batch(2, 0);
    queue_batch(3, 0);
    queue_batch(4, 2);
    queue_batch(5, 0);
    queue_batch(2, 1);
    queue_batch(1, 0);
    queue_batch(7, 0);

    // Sender pause until all results are in.
    drain_req = 1'b1;
    wait (pending_reqs.size() == 0 && sorted_expect.size() == 0);
    @(negedge clk_i);
    drain_req = 1'b0;

    // Full capacity under a long receiver hold-off, then an overflowing batch.
    queue_batch(Cap, 0);
    hold_req = 1'b1;
    queue_batch(Cap + 5, 0);
    repeat (2) @(negedge clk_i);
    hold_req = 1'b0;

    // Random batches: mostly short.
    total = 0;
    while (total < 150) begin
      int unsigned len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, Cap) : $urandom_range(1, 12);
      queue_batch(len, 0);
      total += len;
    end

    wait (pending_reqs.size() == 0 && sorted_expect.size() == 0);
    repeat (TailWait) @(posedge clk_i);
    if (fail_cnt == 0 && sorted_expect.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end
endmodule
